[rtl/core/rsi_pkg.sv]
// Shared constants, types and helper functions for the ray/sphere intersection block.
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int DIR_W     = 18;
    localparam int PROD_W    = VAL_W + DIR_W;
    localparam int HBW_W     = PROD_W + 2;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int CMP_W     = VAL_W + 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 216;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS2  = 2'd3;

    localparam logic signed [VAL_W-1:0] MAX_VAL  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] MIN_VAL  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0]        RADIUS2_RESET = VAL_W'(1) << FRAC_BITS;

    // Values that ride along with the discriminant through the square root
    typedef struct packed {
        logic signed [VAL_W-1:0] hb;
        logic signed [VAL_W-1:0] dist_min;
        logic signed [VAL_W-1:0] dist_max;
        logic                    miss;
    } t_side;

    // Clamp a 33-bit difference into the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat_diff(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > VAL_W'(MAX_VAL) && v > $signed({1'b0, MAX_VAL}))
            res = MAX_VAL;
        else if (v < $signed({1'b1, MIN_VAL}))
            res = MIN_VAL;
        else
            res = v[VAL_W-1:0];
        return res;
    endfunction

    // Floor-shift the dot product and clamp into the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat_hb(input logic signed [HBW_W-1:0] v);
        logic signed [HBW_W-1:0] s;
        logic signed [VAL_W-1:0] res;
        s = v >>> FRAC_BITS;
        if (s > HBW_W'(MAX_VAL))
            res = MAX_VAL;
        else if (s < $signed({{(HBW_W-VAL_W){1'b1}}, MIN_VAL}))
            res = MIN_VAL;
        else
            res = s[VAL_W-1:0];
        return res;
    endfunction

endpackage

[rtl/core/rsi_front.sv]
// Front pipeline: offset, dot products, half linear term and discriminant.
module rsi_front
    import rsi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [IN_W-1:0]         i_data,
    input  logic [VAL_W-1:0]        i_center_x,
    input  logic [VAL_W-1:0]        i_center_y,
    input  logic [VAL_W-1:0]        i_center_z,
    input  logic [VAL_W-1:0]        i_radius2,
    output logic                    o_valid,
    output logic [SQ_W-1:0]         o_disc,
    output t_side                   o_side
);

    logic signed [VAL_W-1:0] org [3];
    logic signed [VAL_W-1:0] cen [3];
    logic signed [DIR_W-1:0] dir [3];

    logic [5:0] r_v;

    logic signed [VAL_W-1:0]  r1_oc [3];
    logic signed [DIR_W-1:0]  r1_d  [3];
    logic signed [VAL_W-1:0]  r1_min, r1_max;

    logic signed [PROD_W-1:0] r2_pd [3];
    logic [SQ_W-1:0]          r2_po [3];
    logic signed [VAL_W-1:0]  r2_min, r2_max;

    logic signed [HBW_W-1:0]  r3_hbw;
    logic [SQ_W-1:0]          r3_ococ;
    logic signed [VAL_W-1:0]  r3_min, r3_max;

    logic signed [VAL_W-1:0]  r4_hb;
    logic [SQ_W-1:0]          r4_ococ;
    logic signed [VAL_W-1:0]  r4_min, r4_max;

    logic signed [VAL_W-1:0]  r5_hb;
    logic [SQ_W-1:0]          r5_hh;
    logic [SQ_W-1:0]          r5_ococ;
    logic signed [VAL_W-1:0]  r5_min, r5_max;

    logic [SQ_W-1:0]          n_pos;
    logic [SQ_W-1:0]          r6_disc;
    t_side                    r6_side;

    // Unpack the input transaction
    assign org[0] = i_data[31:0];
    assign org[1] = i_data[63:32];
    assign org[2] = i_data[95:64];
    assign dir[0] = i_data[113:96];
    assign dir[1] = i_data[131:114];
    assign dir[2] = i_data[149:132];
    assign cen[0] = i_center_x;
    assign cen[1] = i_center_y;
    assign cen[2] = i_center_z;

    assign n_pos = r5_hh + (SQ_W'(i_radius2) << FRAC_BITS);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_oc[k] <= sat_diff((VAL_W+1)'(org[k]) - (VAL_W+1)'(cen[k]));
                r1_d[k]  <= dir[k];
                r2_pd[k] <= PROD_W'(r1_oc[k] * r1_d[k]);
                r2_po[k] <= SQ_W'(r1_oc[k] * r1_oc[k]);
            end
            r1_min <= i_data[181:150];
            r1_max <= i_data[213:182];
            r2_min <= r1_min;
            r2_max <= r1_max;

            r3_hbw  <= HBW_W'(r2_pd[0]) + HBW_W'(r2_pd[1]) + HBW_W'(r2_pd[2]);
            r3_ococ <= r2_po[0] + r2_po[1] + r2_po[2];
            r3_min  <= r2_min;
            r3_max  <= r2_max;

            r4_hb   <= sat_hb(r3_hbw);
            r4_ococ <= r3_ococ;
            r4_min  <= r3_min;
            r4_max  <= r3_max;

            r5_hb   <= r4_hb;
            r5_hh   <= SQ_W'(r4_hb * r4_hb);
            r5_ococ <= r4_ococ;
            r5_min  <= r4_min;
            r5_max  <= r4_max;

            r6_disc          <= n_pos - r5_ococ;
            r6_side.miss     <= n_pos < r5_ococ;
            r6_side.hb       <= r5_hb;
            r6_side.dist_min <= r5_min;
            r6_side.dist_max <= r5_max;
        end
    end

    assign o_valid = r_v[5];
    assign o_disc  = r6_disc;
    assign o_side  = r6_side;

endmodule

[rtl/core/rsi_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_disc,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [ROOT_W:0]     r_v;
    logic [SQ_W-1:0]     r_x    [ROOT_W+1];
    logic [REM_W-1:0]    r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]   r_root [ROOT_W+1];
    t_side               r_side [ROOT_W+1];

    assign r_v[0]    = i_valid;
    assign r_x[0]    = i_disc;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[ROOT_W:1] <= '0;
        end else if (i_en) begin
            r_v[ROOT_W:1] <= r_v[ROOT_W-1:0];
        end
    end

    // Each stage brings down two radicand bits and settles one root bit
    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] trial;
        assign rem_in = {r_rem[g][REM_W-3:0], r_x[g][SQ_W-1 -: 2]};
        assign trial  = REM_W'({r_root[g], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]    <= r_x[g] << 2;
                r_side[g+1] <= r_side[g];
                if (rem_in >= trial) begin
                    r_rem[g+1]  <= rem_in - trial;
                    r_root[g+1] <= {r_root[g][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= rem_in;
                    r_root[g+1] <= {r_root[g][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

[rtl/core/ray_sphere_intersect.sv]
// Ray/sphere intersection top level: configuration, pipeline and root selection.
// Takes one ray per clock while the output is not stalled and returns one
// result per ray, in order: six stages form the offset, the half linear term
// and the discriminant, thirty-two stages resolve the square root one bit each,
// and one stage picks the nearer in-range root into the output register. When
// the output is stalled the whole pipeline holds. Sphere registers must be
// written only while no ray is in flight.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, dist_min, dist_max, pad
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // distance
    output logic [VAL_W-1:0]     m_axis_tdata,
    // hit
    output logic                 m_axis_tuser
);

    logic [VAL_W-1:0] r_center_x, r_center_y, r_center_z, r_radius2;
    logic             en;
    logic             fr_valid, sq_valid;
    logic [SQ_W-1:0]  fr_disc;
    t_side            fr_side, sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic signed [CMP_W-1:0] hb_e, sq_e, near_r, far_r, min_e, max_e;
    logic                    near_in, far_in;
    logic                    r_out_valid, r_hit;
    logic [VAL_W-1:0]        r_dist;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius2  <= RADIUS2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_center_x <= i_cfg_wdata;
                REG_CENTER_Y: r_center_y <= i_cfg_wdata;
                REG_CENTER_Z: r_center_z <= i_cfg_wdata;
                REG_RADIUS2:  r_radius2  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result waits
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    rsi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_axis_tvalid),
        .i_data     (s_axis_tdata),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_radius2  (r_radius2),
        .o_valid    (fr_valid),
        .o_disc     (fr_disc),
        .o_side     (fr_side)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_disc  (fr_disc),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Form both roots and test them against the interval
    assign hb_e    = CMP_W'(sq_side.hb);
    assign sq_e    = $signed(CMP_W'(sq_root));
    assign min_e   = CMP_W'(sq_side.dist_min);
    assign max_e   = CMP_W'(sq_side.dist_max);
    assign near_r  = -hb_e - sq_e;
    assign far_r   = -hb_e + sq_e;
    assign near_in = (near_r >= min_e) && (near_r <= max_e);
    assign far_in  = (far_r >= min_e) && (far_r <= max_e);

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= !sq_side.miss && (near_in || far_in);
            if (sq_side.miss || !(near_in || far_in))
                r_dist <= MAX_VAL;
            else if (near_in)
                r_dist <= near_r[VAL_W-1:0];
            else
                r_dist <= far_r[VAL_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_dist;
    assign m_axis_tuser  = r_hit;

    // A miss always reports the maximum distance
    a_miss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == MAX_VAL)
        else $error("miss without maximum distance");

    // A negative discriminant leaving the root unit becomes a miss
    a_neg_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && sq_valid && sq_side.miss |=> m_axis_tvalid && !m_axis_tuser)
        else $error("negative discriminant reported as hit");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

[bench/rsi_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the ray/sphere block: mirrors the sphere registers, predicts and compares.
module rsi_checker
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, dist_min, dist_max, pad
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // distance
    input  logic [VAL_W-1:0]     m_axis_tdata,
    // hit
    input  logic                 m_axis_tuser,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] distance;
    } t_hit_rec;

    logic [VAL_W-1:0] sph_cx, sph_cy, sph_cz, sph_r2;
    t_hit_rec         hits_due[$];

    // Clamp a wide value into the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Integer square root, floor, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem, acc, b;
        rem = x;
        acc = '0;
        b   = 64'h1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= acc + b) begin
                rem = rem - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    // Work out the nearest in-range root of one ray against the current sphere
    function automatic t_hit_rec trace_sphere(input logic [IN_W-1:0] ray);
        longint      oc [3];
        longint      dv [3];
        longint      cen [3];
        longint      dot_w, hb, sq, root, tmin, tmax;
        logic [63:0] oc_sq, pos, disc;
        t_hit_rec    rec;
        cen[0] = longint'($signed(sph_cx));
        cen[1] = longint'($signed(sph_cy));
        cen[2] = longint'($signed(sph_cz));
        dot_w  = 0;
        oc_sq  = '0;
        for (int k = 0; k < 3; k++) begin
            oc[k] = clamp32(longint'($signed(ray[32*k +: 32])) - cen[k]);
            dv[k] = longint'($signed(ray[96 + 18*k +: 18]));
            dot_w = dot_w + oc[k] * dv[k];
            oc_sq = oc_sq + 64'(oc[k] * oc[k]);
        end
        tmin = longint'($signed(ray[150 +: 32]));
        tmax = longint'($signed(ray[182 +: 32]));
        hb   = clamp32(dot_w >>> FRAC_BITS);
        pos  = 64'(hb * hb) + (64'(sph_r2) << FRAC_BITS);
        rec.hit      = 1'b0;
        rec.distance = MAX_VAL;
        if (pos < oc_sq) return rec;
        disc = pos - oc_sq;
        sq   = longint'(floor_sqrt(disc));
        // Try the nearer root, then the farther one
        root = -hb - sq;
        if (root < tmin || tmax < root) begin
            root = -hb + sq;
            if (root < tmin || tmax < root) return rec;
        end
        rec.hit      = 1'b1;
        rec.distance = root[31:0];
        return rec;
    endfunction

    assign o_pending = hits_due.size();

    // Mirror register writes, queue predictions, compare results
    always @(posedge i_clk) begin
        t_hit_rec want;
        if (!i_rst_n) begin
            sph_cx <= '0;
            sph_cy <= '0;
            sph_cz <= '0;
            sph_r2 <= RADIUS2_RESET;
            hits_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CENTER_X: sph_cx <= i_cfg_wdata;
                    REG_CENTER_Y: sph_cy <= i_cfg_wdata;
                    REG_CENTER_Z: sph_cz <= i_cfg_wdata;
                    REG_RADIUS2:  sph_r2 <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                hits_due.push_back(trace_sphere(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b distance=%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (want.hit !== m_axis_tuser) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, want.hit, m_axis_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.distance !== m_axis_tdata) begin
                        $display("%0t: distance expected %h actual %h",
                                 $time, want.distance, m_axis_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[bench/tb_ray_sphere_intersect.sv]
`timescale 1ns / 100ps
// Testbench top for the ray/sphere block: clock, reset, stimulus and verdict.
module tb_ray_sphere_intersect
    import rsi_pkg::*;
;

    localparam int DRAIN_CYCLES = 50;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [VAL_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    longint               span;

    // Current sphere, kept here to aim rays
    logic [VAL_W-1:0] u_cfg_cx, u_cfg_cy, u_cfg_cz;

    ray_sphere_intersect dut (.*);

    rsi_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver backpressure
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop on a hung run
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [IN_W-1:0] pack_ray(
        input longint ox, oy, oz, dx, dy, dz, dmin, dmax);
        return {2'b00, 32'(dmax), 32'(dmin), 18'(dz), 18'(dy), 18'(dx),
                32'(oz), 32'(oy), 32'(ox)};
    endfunction

    // Offer one ray and hold it until it is taken
    task automatic send_ray(input logic [IN_W-1:0] ray);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_sphere(input logic [VAL_W-1:0] cx, cy, cz, r2);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS2, r2);
    endtask

    // Ray aimed near the sphere with a random unit direction and interval
    task automatic send_aimed_ray;
        real    a, b, c, n;
        longint off [3];
        longint cen [3];
        longint dmin, dmax;
        cen[0] = longint'($signed(u_cfg_cx));
        cen[1] = longint'($signed(u_cfg_cy));
        cen[2] = longint'($signed(u_cfg_cz));
        for (int k = 0; k < 3; k++)
            off[k] = longint'($urandom_range(0, 2 * 32'(span))) - span;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c);
        if (n < 1.0) begin
            a = 0.0; b = 0.0; c = 1.0; n = 1.0;
        end
        dmin = ($urandom_range(3) == 0) ? longint'($signed($urandom()))
                                        : -longint'($urandom_range(0, 4)) * 65536;
        dmax = clamp32(dmin + longint'($urandom()) % (4 * span + 65536));
        if ($urandom_range(9) == 0) dmax = 64'sd2147483647;
        send_ray(pack_ray(clamp32(cen[0] + off[0]), clamp32(cen[1] + off[1]),
                          clamp32(cen[2] + off[2]),
                          longint'($rtoi(a / n * 65536.0)),
                          longint'($rtoi(b / n * 65536.0)),
                          longint'($rtoi(c / n * 65536.0)), dmin, dmax));
    endtask

    task automatic send_noise_ray;
        send_ray(IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom()}));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input logic [VAL_W-1:0] cx, cy, cz, r2, input longint spn);
        drain();
        set_sphere(cx, cy, cz, r2);
        u_cfg_cx = cx;
        u_cfg_cy = cy;
        u_cfg_cz = cz;
        span           = spn;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain();
            if ($urandom_range(9) < 8) send_aimed_ray();
            else send_noise_ray();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        span           = 64'sd8 * 65536;
        u_cfg_cx = '0;
        u_cfg_cy = '0;
        u_cfg_cz = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rays against the reset sphere of radius one at the origin
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 65536, 0, 100 * 65536));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 65536, 5 * 65536, 100 * 65536));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 65536, 7 * 65536, 100 * 65536));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 65536, 4 * 65536, 4 * 65536));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 65536, 100 * 65536, 0));
        send_ray(pack_ray(65536, 0, -5 * 65536, 0, 0, 65536, 0, 100 * 65536));
        send_ray(pack_ray(2 * 65536, 0, -5 * 65536, 0, 0, 65536, 0, 100 * 65536));
        send_ray(pack_ray(0, 0, 0, 65536, 0, 0, -64'sd2147483648, 64'sd2147483647));
        send_ray(pack_ray(0, 0, 5 * 65536, 0, 0, -65536, 0, 64'sd2147483647));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, 131071, 0, 100 * 65536));
        send_ray(pack_ray(0, 0, -5 * 65536, 0, 0, -131072, -100 * 65536, 100 * 65536));
        send_ray(pack_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          -65536, -65536, -65536, -64'sd2147483648, 64'sd2147483647));
        send_ray(pack_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          131071, 131071, 131071, -64'sd2147483648, 64'sd2147483647));
        send_ray(pack_ray(-64'sd2147483648, 0, 64'sd2147483647,
                          -131072, 0, 131071, 0, 0));
        send_ray(pack_ray(0, 0, 0, 0, 0, 0, -65536, 65536));
        send_ray(pack_ray(0, 0, 0, 0, 0, 0, 65536, 64'sd2147483647));

        // Extreme sphere settings
        drain();
        set_sphere(MAX_VAL, MIN_VAL, MAX_VAL, 32'hFFFF_FFFF);
        send_ray(pack_ray(0, 0, 0, 65536, 0, 0, -64'sd2147483648, 64'sd2147483647));
        send_ray(pack_ray(64'sd2147483647, -64'sd2147483648, 64'sd2147483647 - 300 * 65536,
                          0, 0, 65536, 0, 64'sd2147483647));
        send_ray(pack_ray(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                          0, 0, 65536, -64'sd2147483648, 64'sd2147483647));
        drain();
        set_sphere(MIN_VAL, MAX_VAL, MIN_VAL, 32'd0);
        send_ray(pack_ray(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                          65536, 0, 0, -64'sd2147483648, 64'sd2147483647));
        send_ray(pack_ray(0, 0, 0, 65536, -65536, 65536, 0, 64'sd2147483647));

        // Random phases across pacing and sphere settings
        run_phase(0, 0, 375, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  RADIUS2_RESET, 64'sd3 * 65536);
        run_phase(73, 0, 375, 32'h0003_8000, 32'hFFFA_0000, 32'h0010_0000,
                  32'h0019_0000, 64'sd12 * 65536);
        run_phase(0, 73, 375, MAX_VAL, MIN_VAL, 32'h0000_0000,
                  32'hFFFF_FFFF, 64'sd400 * 65536);
        run_phase(12, 12, 375, 32'hFFF0_1234, 32'h0002_ABCD, MIN_VAL,
                  32'd0, 64'sd2 * 65536);

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
